// ===== design/lsfh_pkg.sv =====
// Package for the LIN slave frame handler: shared types, codes and helpers.
// No dependencies; used by every other file of the block.
package lsfh_pkg;

  localparam int ID_COUNT  = 64;
  localparam int ID_W      = 6;
  localparam int SLOT_W    = 3;                 // byte slots per identifier: 2**SLOT_W
  localparam int SLOT_CNT  = 1 << SLOT_W;
  localparam int RSP_DEPTH = ID_COUNT * SLOT_CNT;
  localparam int RSP_AW    = ID_W + SLOT_W;
  localparam int SET_W     = 7;                 // [3:0] len, [4] enhanced, [5] rx, [6] tx

  localparam logic [7:0] SYNC_BYTE = 8'h55;

  // input opcodes
  localparam logic [2:0] OP_BYTE    = 3'd0;
  localparam logic [2:0] OP_BREAK   = 3'd1;
  localparam logic [2:0] OP_TIMEOUT = 3'd2;
  localparam logic [2:0] OP_SET     = 3'd3;
  localparam logic [2:0] OP_RESP    = 3'd4;

  // result kinds
  localparam logic [2:0] K_TX      = 3'd0;
  localparam logic [2:0] K_RX      = 3'd1;
  localparam logic [2:0] K_PROTO   = 3'd2;
  localparam logic [2:0] K_CKS     = 3'd3;
  localparam logic [2:0] K_TIMEOUT = 3'd4;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_SYNC = 5'b00010,
    PH_ID   = 5'b00100,
    PH_DATA = 5'b01000,
    PH_CKS  = 5'b10000
  } phase_t;

  typedef enum logic [8:0] {
    SQ_IDLE  = 9'b000000001,
    SQ_EXEC  = 9'b000000010,
    SQ_SET   = 9'b000000100,
    SQ_TXRD  = 9'b000001000,
    SQ_TXOUT = 9'b000010000,
    SQ_TXCK  = 9'b000100000,
    SQ_RXRD  = 9'b001000000,
    SQ_RXOUT = 9'b010000000,
    SQ_SPARE = 9'b100000000
  } seq_t;

  typedef struct packed {
    logic [2:0]      opcode;
    logic [7:0]      byte_value;
    logic [ID_W-1:0] entry_id;
    logic [2:0]      entry_index;
    logic [3:0]      entry_len;
    logic            enhanced;
    logic            rx_enable;
    logic            tx_enable;
  } item_t;

  // requests into the identifier tables
  typedef struct packed {
    logic              set_we;
    logic              set_re;
    logic [ID_W-1:0]   set_id;
    logic [SET_W-1:0]  set_wdata;
    logic              rsp_we;
    logic              rsp_re;
    logic [RSP_AW-1:0] rsp_addr;
    logic [7:0]        rsp_wdata;
  } tab_req_t;

  // requests into the received data buffer
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [SLOT_W-1:0] raddr;
  } rxb_req_t;

  // carry-sum step: add, fold the carry back in
  function automatic logic [7:0] carry_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[7:0] + {7'd0, s[8]};
  endfunction

  // protected identifier with both parity bits
  function automatic logic [7:0] protect_id(input logic [ID_W-1:0] id);
    logic p0;
    logic p1;
    p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
    p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
    return {p1, p0, id};
  endfunction

endpackage

// ===== design/lsfh_tables.sv =====
// Identifier tables: per-ID settings (cleared by valid bits) and response bytes.
// Depends on lsfh_pkg. Both stores have a registered read.
module lsfh_tables (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lsfh_pkg::tab_req_t            req,
  output logic [lsfh_pkg::SET_W-1:0]    set_rdata,
  output logic [7:0]                    rsp_rdata
);

  logic [lsfh_pkg::SET_W-1:0]    set_mem_r [lsfh_pkg::ID_COUNT];
  logic [lsfh_pkg::ID_COUNT-1:0] set_vld_r;
  logic [lsfh_pkg::SET_W-1:0]    set_rd_r;
  logic                          set_rd_vld_r;
  logic [7:0]                    rsp_mem_r [lsfh_pkg::RSP_DEPTH];
  logic [7:0]                    rsp_rd_r;

  always_ff @(posedge clk) begin
    if (req.set_we) begin
      set_mem_r[req.set_id] <= req.set_wdata;
    end
    if (req.set_re) begin
      set_rd_r <= set_mem_r[req.set_id];
    end
  end

  // entries never written read as zero: all identifiers disabled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_vld_r    <= '0;
      set_rd_vld_r <= 1'b0;
    end else begin
      if (req.set_we) begin
        set_vld_r[req.set_id] <= 1'b1;
      end
      if (req.set_re) begin
        set_rd_vld_r <= set_vld_r[req.set_id];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.rsp_we) begin
      rsp_mem_r[req.rsp_addr] <= req.rsp_wdata;
    end
    if (req.rsp_re) begin
      rsp_rd_r <= rsp_mem_r[req.rsp_addr];
    end
  end

  assign set_rdata = set_rd_vld_r ? set_rd_r : '0;
  assign rsp_rdata = rsp_rd_r;

endmodule

// ===== design/lsfh_rxbuf.sv =====
// Received data buffer: one frame's data bytes, registered read.
// Depends on lsfh_pkg.
module lsfh_rxbuf (
  input  logic               clk,
  input  lsfh_pkg::rxb_req_t req,
  output logic [7:0]         rd_data
);

  logic [7:0] buf_mem_r [lsfh_pkg::SLOT_CNT];
  logic [7:0] rd_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      buf_mem_r[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_r <= buf_mem_r[req.raddr];
    end
  end

  assign rd_data = rd_r;

endmodule

// ===== design/lin_slave_frame_handler.sv =====
// LIN slave frame handler, top level: word sequencer, frame phase and output register.
// Depends on lsfh_pkg, lsfh_tables and lsfh_rxbuf.
// Single result word (error, timeout): input word into item_r, result into the output
// register from the execute state once it is free. A new input word waits until the last
// is done; tx/rx bytes are read one by one through the table or buffer memory read port.
// Reset: synchronous, rst_n low; frame idle, all identifiers disabled, no clearing pass.
module lin_slave_frame_handler #(
  parameter int MAX_DATA = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] byte_value, [13:8] entry_id, [16:14] entry_index, [20:17] entry_len,
  // [21] enhanced, [22] rx_enable, [23] tx_enable
  input  logic [23:0] in_tdata,
  input  logic [2:0]  in_tuser,   // [2:0] opcode
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [13:8] frame_id, [15:14] zero
  output logic [2:0]  out_tuser,  // [2:0] kind
  output logic        out_tlast   // last
);

  localparam logic [3:0] MAX_LEN = 4'(MAX_DATA);

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  lsfh_pkg::seq_t   seq_r,   seq_nxt;
  lsfh_pkg::phase_t phase_r, phase_nxt;
  lsfh_pkg::item_t  item_r;

  logic [lsfh_pkg::ID_W-1:0] cur_frame_r, cur_frame_nxt;
  logic [3:0]                exp_len_r,   exp_len_nxt;
  logic [3:0]                seen_r,      seen_nxt;
  logic [7:0]                rx_sum_r,    rx_sum_nxt;
  logic [7:0]                tx_sum_r,    tx_sum_nxt;
  logic [3:0]                tx_len_r,    tx_len_nxt;
  logic [3:0]                cnt_r,       cnt_nxt;   // byte counter of the running emission

  logic                      out_valid_r, out_valid_nxt;
  logic [2:0]                out_kind_r;
  logic [7:0]                out_byte_r;
  logic [lsfh_pkg::ID_W-1:0] out_id_r;
  logic                      out_last_r;

  // output load request from the sequencer
  logic                      out_free;
  logic                      out_load;
  logic [2:0]                ld_kind;
  logic [7:0]                ld_byte;
  logic [lsfh_pkg::ID_W-1:0] ld_id;
  logic                      ld_last;

  lsfh_pkg::tab_req_t          tab_req;
  lsfh_pkg::rxb_req_t          rxb_req;
  logic [lsfh_pkg::SET_W-1:0]  set_rdata;
  logic [7:0]                  rsp_rdata;
  logic [7:0]                  rxb_rdata;

  logic                        in_acc;
  logic [lsfh_pkg::ID_W-1:0]   pid_id;
  logic [3:0]                  set_len;
  logic [7:0]                  sum_seed;
  logic [3:0]                  clamp_len;
  logic [3:0]                  cnt_inc;

  // ---------------------------------------------------------------------------
  // Memories
  // ---------------------------------------------------------------------------
  lsfh_tables u_tables (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (tab_req),
    .set_rdata (set_rdata),
    .rsp_rdata (rsp_rdata)
  );

  lsfh_rxbuf u_rxbuf (
    .clk     (clk),
    .req     (rxb_req),
    .rd_data (rxb_rdata)
  );

  // Take a new word only with the sequencer at rest; every memory access of one word
  // is finished before the next one starts, so the memories need no forwarding.
  assign in_tready = (seq_r == lsfh_pkg::SQ_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign pid_id  = item_r.byte_value[lsfh_pkg::ID_W-1:0];
  assign set_len = (set_rdata[3:0] > 4'd8) ? 4'd8 : set_rdata[3:0];
  // seed the checksum with the PID for the enhanced type
  assign sum_seed = set_rdata[4] ? item_r.byte_value : 8'd0;
  assign cnt_inc  = cnt_r + 4'd1;

  always_comb begin
    if (item_r.entry_len == 4'd0) begin
      clamp_len = 4'd1;
    end else if (item_r.entry_len > MAX_LEN) begin
      clamp_len = MAX_LEN;
    end else begin
      clamp_len = item_r.entry_len;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    seq_nxt       = seq_r;
    phase_nxt     = phase_r;
    cur_frame_nxt = cur_frame_r;
    exp_len_nxt   = exp_len_r;
    seen_nxt      = seen_r;
    rx_sum_nxt    = rx_sum_r;
    tx_sum_nxt    = tx_sum_r;
    tx_len_nxt    = tx_len_r;
    cnt_nxt       = cnt_r;
    out_load      = 1'b0;
    ld_kind       = lsfh_pkg::K_TX;
    ld_byte       = 8'd0;
    ld_id         = cur_frame_r;
    ld_last       = 1'b1;
    tab_req       = '0;
    rxb_req       = '0;

    case (seq_r)
      lsfh_pkg::SQ_IDLE: begin
        if (in_acc) begin
          seq_nxt = lsfh_pkg::SQ_EXEC;
        end
      end

      lsfh_pkg::SQ_EXEC: begin
        seq_nxt = lsfh_pkg::SQ_IDLE;
        case (item_r.opcode)
          lsfh_pkg::OP_BYTE: begin
            case (phase_r)
              lsfh_pkg::PH_SYNC: begin
                if (item_r.byte_value != lsfh_pkg::SYNC_BYTE) begin
                  // hold until the error word fits
                  if (out_free) begin
                    out_load  = 1'b1;
                    ld_kind   = lsfh_pkg::K_PROTO;
                    ld_id     = '0;
                    phase_nxt = lsfh_pkg::PH_IDLE;
                  end else begin
                    seq_nxt = lsfh_pkg::SQ_EXEC;
                  end
                end else begin
                  phase_nxt = lsfh_pkg::PH_ID;
                end
              end
              lsfh_pkg::PH_ID: begin
                if (lsfh_pkg::protect_id(pid_id) != item_r.byte_value) begin
                  if (out_free) begin
                    out_load  = 1'b1;
                    ld_kind   = lsfh_pkg::K_PROTO;
                    ld_id     = pid_id;
                    phase_nxt = lsfh_pkg::PH_IDLE;
                  end else begin
                    seq_nxt = lsfh_pkg::SQ_EXEC;
                  end
                end else begin
                  cur_frame_nxt  = pid_id;
                  tab_req.set_re = 1'b1;
                  tab_req.set_id = pid_id;
                  seq_nxt        = lsfh_pkg::SQ_SET;
                end
              end
              lsfh_pkg::PH_DATA: begin
                rxb_req.we    = 1'b1;
                rxb_req.waddr = seen_r[lsfh_pkg::SLOT_W-1:0];
                rxb_req.wdata = item_r.byte_value;
                rx_sum_nxt    = lsfh_pkg::carry_add(rx_sum_r, item_r.byte_value);
                seen_nxt      = seen_r + 4'd1;
                if (seen_nxt >= exp_len_r) begin
                  phase_nxt = lsfh_pkg::PH_CKS;
                end
              end
              lsfh_pkg::PH_CKS: begin
                if (item_r.byte_value != ~rx_sum_r) begin
                  if (out_free) begin
                    out_load  = 1'b1;
                    ld_kind   = lsfh_pkg::K_CKS;
                    phase_nxt = lsfh_pkg::PH_IDLE;
                  end else begin
                    seq_nxt = lsfh_pkg::SQ_EXEC;
                  end
                end else begin
                  phase_nxt = lsfh_pkg::PH_IDLE;
                  cnt_nxt   = 4'd0;
                  if (exp_len_r != 4'd0) begin
                    seq_nxt = lsfh_pkg::SQ_RXRD;
                  end
                end
              end
              default: begin
                // byte while idle: drop
              end
            endcase
          end
          lsfh_pkg::OP_BREAK: begin
            phase_nxt = lsfh_pkg::PH_SYNC;
          end
          lsfh_pkg::OP_TIMEOUT: begin
            if (phase_r != lsfh_pkg::PH_IDLE) begin
              if (out_free) begin
                out_load  = 1'b1;
                ld_kind   = lsfh_pkg::K_TIMEOUT;
                phase_nxt = lsfh_pkg::PH_IDLE;
              end else begin
                seq_nxt = lsfh_pkg::SQ_EXEC;
              end
            end
          end
          lsfh_pkg::OP_SET: begin
            tab_req.set_we    = 1'b1;
            tab_req.set_id    = item_r.entry_id;
            tab_req.set_wdata = {item_r.tx_enable, item_r.rx_enable, item_r.enhanced,
                                 clamp_len};
          end
          lsfh_pkg::OP_RESP: begin
            tab_req.rsp_we    = ({1'b0, item_r.entry_index} < MAX_LEN);
            tab_req.rsp_addr  = {item_r.entry_id, item_r.entry_index};
            tab_req.rsp_wdata = item_r.byte_value;
          end
          default: begin
            // unknown opcode: nothing
          end
        endcase
      end

      lsfh_pkg::SQ_SET: begin
        // settings for the new frame are on the table read port
        tx_sum_nxt = sum_seed;
        tx_len_nxt = set_len;
        cnt_nxt    = 4'd0;
        if (set_rdata[5]) begin
          exp_len_nxt = set_len;
          seen_nxt    = 4'd0;
          rx_sum_nxt  = sum_seed;
          phase_nxt   = (set_len == 4'd0) ? lsfh_pkg::PH_CKS : lsfh_pkg::PH_DATA;
        end else begin
          phase_nxt = lsfh_pkg::PH_IDLE;
        end
        if (set_rdata[6]) begin
          seq_nxt = (set_len == 4'd0) ? lsfh_pkg::SQ_TXCK : lsfh_pkg::SQ_TXRD;
        end else begin
          seq_nxt = lsfh_pkg::SQ_IDLE;
        end
      end

      lsfh_pkg::SQ_TXRD: begin
        tab_req.rsp_re   = 1'b1;
        tab_req.rsp_addr = {cur_frame_r, cnt_r[lsfh_pkg::SLOT_W-1:0]};
        seq_nxt          = lsfh_pkg::SQ_TXOUT;
      end

      lsfh_pkg::SQ_TXOUT: begin
        if (out_free) begin
          out_load   = 1'b1;
          ld_kind    = lsfh_pkg::K_TX;
          ld_byte    = rsp_rdata;
          ld_last    = 1'b0;
          tx_sum_nxt = lsfh_pkg::carry_add(tx_sum_r, rsp_rdata);
          cnt_nxt    = cnt_inc;
          seq_nxt    = (cnt_inc >= tx_len_r) ? lsfh_pkg::SQ_TXCK : lsfh_pkg::SQ_TXRD;
        end
      end

      lsfh_pkg::SQ_TXCK: begin
        if (out_free) begin
          out_load = 1'b1;
          ld_kind  = lsfh_pkg::K_TX;
          ld_byte  = ~tx_sum_r;
          seq_nxt  = lsfh_pkg::SQ_IDLE;
        end
      end

      lsfh_pkg::SQ_RXRD: begin
        rxb_req.re    = 1'b1;
        rxb_req.raddr = cnt_r[lsfh_pkg::SLOT_W-1:0];
        seq_nxt       = lsfh_pkg::SQ_RXOUT;
      end

      lsfh_pkg::SQ_RXOUT: begin
        if (out_free) begin
          out_load = 1'b1;
          ld_kind  = lsfh_pkg::K_RX;
          ld_byte  = rxb_rdata;
          ld_last  = (cnt_inc >= exp_len_r);
          cnt_nxt  = cnt_inc;
          seq_nxt  = (cnt_inc >= exp_len_r) ? lsfh_pkg::SQ_IDLE : lsfh_pkg::SQ_RXRD;
        end
      end

      default: begin
        seq_nxt = lsfh_pkg::SQ_IDLE;
      end
    endcase

    out_valid_nxt = out_load || (out_valid_r && !out_tready);
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r       <= lsfh_pkg::SQ_IDLE;
      phase_r     <= lsfh_pkg::PH_IDLE;
      cur_frame_r <= '0;
      exp_len_r   <= '0;
      seen_r      <= '0;
      rx_sum_r    <= '0;
      tx_sum_r    <= '0;
      tx_len_r    <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      seq_r       <= seq_nxt;
      phase_r     <= phase_nxt;
      cur_frame_r <= cur_frame_nxt;
      exp_len_r   <= exp_len_nxt;
      seen_r      <= seen_nxt;
      rx_sum_r    <= rx_sum_nxt;
      tx_sum_r    <= tx_sum_nxt;
      tx_len_r    <= tx_len_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // capture the input word; held until the next one is taken
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r.opcode      <= in_tuser;
      item_r.byte_value  <= in_tdata[7:0];
      item_r.entry_id    <= in_tdata[13:8];
      item_r.entry_index <= in_tdata[16:14];
      item_r.entry_len   <= in_tdata[20:17];
      item_r.enhanced    <= in_tdata[21];
      item_r.rx_enable   <= in_tdata[22];
      item_r.tx_enable   <= in_tdata[23];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind_r <= ld_kind;
      out_byte_r <= ld_byte;
      out_id_r   <= ld_id;
      out_last_r <= ld_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_id_r, out_byte_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_load && out_valid_r && !out_tready))
    else $error("output word overwritten while stalled");

  a_tx_check_last: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r == lsfh_pkg::SQ_TXCK && out_free) |=>
      (out_tvalid && out_tlast && out_tuser == lsfh_pkg::K_TX))
    else $error("tx checksum word not marked last");

  a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == lsfh_pkg::PH_DATA) |-> (seen_r < exp_len_r))
    else $error("data byte count past expected length");

  a_tx_count: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r == lsfh_pkg::SQ_TXOUT) |-> (cnt_r < tx_len_r))
    else $error("tx byte counter past response length");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (seq_r == lsfh_pkg::SQ_EXEC && !in_tready))
    else $error("input word taken while a word is in progress");

endmodule

// ===== tb/lin_slave_frame_handler_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for lin_slave_frame_handler: directed table, then random LIN frames.
// Depends on lsfh_pkg and the block; predicts every result word and checks it in order.
module lin_slave_frame_handler_tb;
  import lsfh_pkg::*;

  localparam int          DATA_MAX   = 8;
  localparam logic [2:0]  OP_SPARE   = 3'd7;   // opcodes above OP_RESP do nothing
  localparam int          LONG_HOLD  = 200;    // cycles the sink holds off under pressure
  localparam int          WATCHDOG   = 2000;   // cycles with no word moving on either side
  localparam int          SETTLE     = 40;
  localparam int          MID_WORDS  = 70;
  localparam int          BUSY_WORDS = 150;
  localparam int          ALL_WORDS  = 200;

  // one result word as the block presents it
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic [5:0] fid;
    logic       last;
  } lin_res_t;

  // per input word: whether the result is typed in by hand, and that result
  typedef struct packed {
    logic     typed;
    logic     has_res;
    lin_res_t res;
  } tag_t;

  typedef struct packed {
    item_t    w;
    tag_t     tag;
  } drow_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;
  logic [2:0]  in_tuser   = OP_BYTE;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  lin_slave_frame_handler #(.MAX_DATA(DATA_MAX)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Frame predictor state, kept apart from the generator's own view of the tables
  phase_t     ph = PH_IDLE;
  logic [5:0] cur_id;
  logic [3:0] want_len;
  logic [3:0] got_cnt;
  logic [7:0] sum_acc;
  logic [7:0] rx_buf  [DATA_MAX];
  logic [6:0] id_tab  [ID_COUNT];
  logic [7:0] rsp_mem [RSP_DEPTH];

  lin_res_t   fresh[$];         // results of the word being predicted
  lin_res_t   owed[$];          // results still to come from the block
  tag_t       word_tags[$];     // one per word offered, popped on acceptance
  drow_t      plan[$];

  // Generator view: settings written so far and which response bytes are known
  logic [6:0] gen_set   [ID_COUNT] = '{default: '0};
  logic [7:0] rsp_known [ID_COUNT] = '{default: '0};

  logic       calm     = 1'b0;  // no idling on either side once set
  logic       hold_req = 1'b0;  // ask the sink for one long hold-off
  int         words_sent = 0;
  int         n_faults   = 0;
  int         quiet_cycles = 0;

  // LIN carry-sum step: wrap the carry round into bit 0
  function automatic logic [7:0] fold_add(logic [7:0] a, logic [7:0] b);
    int s;
    s = int'(a) + int'(b);
    if (s > 255) s -= 255;
    return 8'(s);
  endfunction

  // protected identifier: P0 over bits 0,1,2,4 and inverted P1 over bits 1,3,4,5
  function automatic logic [7:0] lin_pid(logic [5:0] id);
    logic [7:0] pid;
    pid    = {2'b00, id};
    pid[6] = ^(id & 6'b010111);
    pid[7] = ~^(id & 6'b111010);
    return pid;
  endfunction

  function automatic int eff_len(logic [3:0] len);
    if (len == 4'd0) return 1;
    if (len > DATA_MAX) return DATA_MAX;
    return int'(len);
  endfunction

  function automatic void emit(logic [2:0] k, logic [7:0] b, logic [5:0] f);
    fresh.push_back('{k, b, f, 1'b0});
  endfunction

  // Advance the frame by one accepted word and collect the results it causes
  function automatic void frame_step(item_t w);
    logic [7:0] c;
    logic [7:0] acc;
    logic [7:0] b;
    logic [5:0] fid;
    logic [6:0] ent;
    lin_res_t   tail;
    int         n;
    fresh.delete();
    c = w.byte_value;
    case (w.opcode)
      OP_BYTE: begin
        case (ph)
          PH_SYNC: begin
            if (c != SYNC_BYTE) begin
              emit(K_PROTO, 8'h00, 6'd0);
              ph = PH_IDLE;
            end else begin
              ph = PH_ID;
            end
          end
          PH_ID: begin
            fid = c[5:0];
            if (lin_pid(fid) != c) begin
              emit(K_PROTO, 8'h00, fid);
              ph = PH_IDLE;
            end else begin
              cur_id = fid;
              ent    = id_tab[fid];
              n      = int'(ent[3:0]);
              if (n > DATA_MAX) n = DATA_MAX;
              // tx response: stored bytes, then the inverted sum
              if (ent[6]) begin
                acc = ent[4] ? c : 8'h00;
                for (int k = 0; k < n; k++) begin
                  b   = rsp_mem[int'(fid) * DATA_MAX + k];
                  acc = fold_add(acc, b);
                  emit(K_TX, b, fid);
                end
                emit(K_TX, ~acc, fid);
              end
              if (ent[5]) begin
                want_len = 4'(n);
                got_cnt  = 4'd0;
                sum_acc  = ent[4] ? c : 8'h00;
                ph       = (n == 0) ? PH_CKS : PH_DATA;
              end else begin
                ph = PH_IDLE;
              end
            end
          end
          PH_DATA: begin
            rx_buf[got_cnt[2:0]] = c;
            sum_acc = fold_add(sum_acc, c);
            got_cnt = got_cnt + 4'd1;
            if (got_cnt >= want_len) ph = PH_CKS;
          end
          PH_CKS: begin
            ph = PH_IDLE;
            if (c != ~sum_acc) begin
              emit(K_CKS, 8'h00, cur_id);
            end else begin
              for (int k = 0; k < int'(want_len) && k < DATA_MAX; k++)
                emit(K_RX, rx_buf[k], cur_id);
            end
          end
          default: ;   // idle: drop the byte
        endcase
      end
      OP_BREAK: ph = PH_SYNC;
      OP_TIMEOUT: begin
        if (ph != PH_IDLE) begin
          ph = PH_IDLE;
          emit(K_TIMEOUT, 8'h00, cur_id);
        end
      end
      OP_SET: id_tab[w.entry_id] = {w.tx_enable, w.rx_enable, w.enhanced,
                                    4'(eff_len(w.entry_len))};
      OP_RESP: rsp_mem[int'(w.entry_id) * DATA_MAX + int'(w.entry_index)] = w.byte_value;
      default: ;
    endcase
    if (fresh.size() != 0) begin
      tail      = fresh.pop_back();
      tail.last = 1'b1;
      fresh.push_back(tail);
    end
  endfunction

  function automatic void log_fault(string what, lin_res_t e, lin_res_t g);
    string exp_s;
    string got_s;
    exp_s = $sformatf("kind %0d byte %02h id %0d last %0d", e.kind, e.data, e.fid, e.last);
    got_s = $sformatf("kind %0d byte %02h id %0d last %0d", g.kind, g.data, g.fid, g.last);
    if (n_faults < 10)
      $display("%0t %s: expected %s, got %s", $time, what, exp_s, got_s);
    n_faults++;
  endfunction

  // Monitor: predict on every accepted input word, check every accepted result word
  always @(posedge clk) begin : watch
    item_t    w;
    tag_t     tg;
    lin_res_t got;
    lin_res_t want;
    if (!rst_n) begin
      ph       = PH_IDLE;
      cur_id   = '0;
      want_len = '0;
      got_cnt  = '0;
      sum_acc  = '0;
      foreach (id_tab[i]) id_tab[i] = '0;
    end else begin
      if (in_tvalid && in_tready) begin
        w.opcode = in_tuser;
        {w.tx_enable, w.rx_enable, w.enhanced, w.entry_len, w.entry_index,
         w.entry_id, w.byte_value} = in_tdata;
        frame_step(w);
        tg = word_tags.pop_front();
        // hand-typed rows override the predictor; its state still advances
        if (tg.typed) begin
          if (tg.has_res) owed.push_back(tg.res);
        end else begin
          foreach (fresh[i]) owed.push_back(fresh[i]);
        end
      end
      if (out_tvalid && out_tready) begin
        got.kind = out_tuser;
        got.data = out_tdata[7:0];
        got.fid  = out_tdata[13:8];
        got.last = out_tlast;
        if (owed.size() == 0) begin
          log_fault("result with nothing owed", '0, got);
        end else begin
          want = owed.pop_front();
          if (want.kind != got.kind || want.data != got.data ||
              want.fid != got.fid || want.last != got.last)
            log_fault("result mismatch", want, got);
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG) begin
      $display("lin_slave_frame_handler_tb NOT OK");
      $finish;
    end
  end

  // Sink: bursts of back-pressure, one long hold-off on request, none once calm
  initial begin : sink
    int span;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        span = LONG_HOLD;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        span = $urandom_range(1, 14);
      end else begin
        out_tready <= 1'b1;
        span = $urandom_range(1, 24);
      end
      repeat (span) @(posedge clk);
    end
  end

  function automatic item_t mk(logic [2:0] op, logic [7:0] b, logic [5:0] id,
                               logic [2:0] idx, logic [3:0] len, logic [2:0] etx);
    item_t w;
    w.opcode      = op;
    w.byte_value  = b;
    w.entry_id    = id;
    w.entry_index = idx;
    w.entry_len   = len;
    {w.tx_enable, w.rx_enable, w.enhanced} = etx;
    return w;
  endfunction

  // bus event with junk in the fields it does not use
  function automatic item_t bus(logic [2:0] op, logic [7:0] b);
    logic [31:0] r;
    item_t       w;
    r            = $urandom;
    w            = r[26:0];
    w.opcode     = op;
    w.byte_value = b;
    return w;
  endfunction

  function automatic drow_t no_res(item_t w);
    return '{w, '{1'b1, 1'b0, '0}};
  endfunction

  function automatic drow_t one_res(item_t w, logic [2:0] k, logic [5:0] f);
    return '{w, '{1'b1, 1'b1, '{k, 8'h00, f, 1'b1}}};
  endfunction

  function automatic drow_t by_model(item_t w);
    return '{w, '{1'b0, 1'b0, '0}};
  endfunction

  // Offer one word, hold it until taken, then maybe idle for a burst
  task automatic issue(item_t w, tag_t tg = '0);
    word_tags.push_back(tg);
    case (w.opcode)
      OP_SET:  gen_set[w.entry_id] = {w.tx_enable, w.rx_enable, w.enhanced,
                                      4'(eff_len(w.entry_len))};
      OP_RESP: rsp_known[w.entry_id][w.entry_index] = 1'b1;
      default: ;
    endcase
    if (w.opcode <= OP_RESP) words_sent++;
    in_tvalid <= 1'b1;
    in_tdata  <= {w.tx_enable, w.rx_enable, w.enhanced, w.entry_len, w.entry_index,
                  w.entry_id, w.byte_value};
    in_tuser  <= w.opcode;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // Write an identifier's settings; a tx entry gets its missing response bytes first
  task automatic set_entry(logic [5:0] fid, logic [3:0] len, logic [2:0] etx);
    int n;
    n = eff_len(len);
    if (etx[2])
      for (int k = 0; k < n; k++)
        if (!rsp_known[fid][k])
          issue(mk(OP_RESP, 8'($urandom), fid, 3'(k), 4'($urandom), 3'($urandom)));
    issue(mk(OP_SET, 8'($urandom), fid, 3'($urandom), len, etx));
  endtask

  // Well-formed frame: break, sync, PID, then data and checksum where rx is on
  task automatic run_frame(logic push_tx);
    logic [5:0] fid;
    logic [6:0] ent;
    logic [7:0] pid;
    logic [7:0] acc;
    logic [7:0] b;
    fid = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7));
    if (push_tx)
      set_entry(fid, 4'd8, 3'b100);
    else if (gen_set[fid] == 7'd0 || $urandom_range(0, 2) == 0)
      set_entry(fid, 4'($urandom), 3'($urandom));
    if ($urandom_range(0, 3) == 0)
      issue(mk(OP_RESP, 8'($urandom), fid, 3'($urandom), 4'($urandom), 3'($urandom)));
    ent = gen_set[fid];
    pid = lin_pid(fid);
    issue(bus(OP_BREAK, 8'($urandom)));
    issue(bus(OP_BYTE, SYNC_BYTE));
    issue(bus(OP_BYTE, pid));
    if (ent[5]) begin
      acc = ent[4] ? pid : 8'h00;
      for (int k = 0; k < int'(ent[3:0]); k++) begin
        b   = 8'($urandom);
        acc = fold_add(acc, b);
        issue(bus(OP_BYTE, b));
      end
      // mostly a good checksum, now and then a corrupt one
      issue(bus(OP_BYTE, ($urandom_range(0, 4) == 0) ? 8'($urandom) : ~acc));
    end
  endtask

  // Broken frames: bad sync, bad parity, dropped frame, timeouts mid-header
  task automatic run_broken();
    logic [5:0] fid;
    logic [7:0] flip;
    fid  = 6'($urandom);
    flip = {2'($urandom_range(1, 3)), 6'd0};
    issue(bus(OP_BREAK, 8'($urandom)));
    case ($urandom_range(0, 4))
      0: issue(bus(OP_BYTE, 8'($urandom)));
      1: begin
        issue(bus(OP_BYTE, SYNC_BYTE));
        issue(bus(OP_BYTE, lin_pid(fid) ^ flip));
      end
      2: begin
        issue(bus(OP_BYTE, SYNC_BYTE));
        issue(bus(OP_BYTE, lin_pid(fid)));
        issue(bus(OP_BYTE, 8'($urandom)));
        issue(bus(OP_BREAK, 8'($urandom)));
        issue(bus(OP_TIMEOUT, 8'($urandom)));
      end
      3: issue(bus(OP_TIMEOUT, 8'($urandom)));
      default: begin
        issue(bus(OP_BYTE, SYNC_BYTE));
        issue(bus(OP_TIMEOUT, 8'($urandom)));
      end
    endcase
  endtask

  task automatic run_noise();
    logic [2:0] op;
    op = 3'($urandom);
    if (op == OP_SET) set_entry(6'($urandom), 4'($urandom), 3'($urandom));
    else issue(bus(op, 8'($urandom)));
  endtask

  task automatic episode();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 13) run_frame(1'b0);
    else if (pick < 16) run_broken();
    else run_noise();
  endtask

  // Stop offering and wait until every word is taken and every result has come
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (word_tags.size() != 0 || owed.size() != 0);
  endtask

  initial begin : stimulus
    // directed table: idle behaviour, header errors, tx+rx on one id, good rx frame
    plan.push_back(no_res(mk(OP_BYTE, SYNC_BYTE, 6'd0, 3'd0, 4'd0, 3'b000)));
    plan.push_back(no_res(mk(OP_TIMEOUT, 8'h00, 6'd0, 3'd0, 4'd0, 3'b000)));
    plan.push_back(no_res(mk(OP_SPARE, 8'hFF, 6'h3F, 3'd7, 4'hF, 3'b111)));
    plan.push_back(no_res(mk(OP_BREAK, 8'h00, 6'd0, 3'd0, 4'd0, 3'b000)));
    plan.push_back(one_res(mk(OP_BYTE, 8'h00, 6'd0, 3'd0, 4'd0, 3'b000), K_PROTO, 6'd0));
    plan.push_back(no_res(mk(OP_BREAK, 8'h00, 6'd0, 3'd0, 4'd0, 3'b000)));
    plan.push_back(no_res(mk(OP_BYTE, SYNC_BYTE, 6'd0, 3'd0, 4'd0, 3'b000)));
    plan.push_back(one_res(mk(OP_BYTE, 8'hFF, 6'd0, 3'd0, 4'd0, 3'b000), K_PROTO, 6'h3F));
    plan.push_back(no_res(mk(OP_BREAK, 8'h00, 6'd0, 3'd0, 4'd0, 3'b000)));
    plan.push_back(one_res(mk(OP_TIMEOUT, 8'h00, 6'd0, 3'd0, 4'd0, 3'b000), K_TIMEOUT, 6'd0));
    plan.push_back(by_model(mk(OP_RESP, 8'hA5, 6'h3F, 3'd7, 4'd0, 3'b000)));
    plan.push_back(by_model(mk(OP_RESP, 8'hFF, 6'h3F, 3'd0, 4'd0, 3'b000)));
    plan.push_back(by_model(mk(OP_SET, 8'h00, 6'h3F, 3'd0, 4'd0, 3'b111)));
    plan.push_back(by_model(mk(OP_BREAK, 8'h00, 6'd0, 3'd0, 4'd0, 3'b000)));
    plan.push_back(by_model(mk(OP_BYTE, SYNC_BYTE, 6'd0, 3'd0, 4'd0, 3'b000)));
    plan.push_back(by_model(mk(OP_BYTE, lin_pid(6'h3F), 6'd0, 3'd0, 4'd0, 3'b000)));
    plan.push_back(by_model(mk(OP_BYTE, 8'h00, 6'd0, 3'd0, 4'd0, 3'b000)));
    plan.push_back(one_res(mk(OP_BYTE, 8'h00, 6'd0, 3'd0, 4'd0, 3'b000), K_CKS, 6'h3F));
    plan.push_back(by_model(mk(OP_SET, 8'h00, 6'd1, 3'd0, 4'd1, 3'b010)));
    plan.push_back(by_model(mk(OP_BREAK, 8'h00, 6'd0, 3'd0, 4'd0, 3'b000)));
    plan.push_back(by_model(mk(OP_BYTE, SYNC_BYTE, 6'd0, 3'd0, 4'd0, 3'b000)));
    plan.push_back(by_model(mk(OP_BYTE, lin_pid(6'd1), 6'd0, 3'd0, 4'd0, 3'b000)));
    plan.push_back(by_model(mk(OP_BYTE, 8'h7E, 6'd0, 3'd0, 4'd0, 3'b000)));
    plan.push_back(by_model(mk(OP_BYTE, 8'h81, 6'd0, 3'd0, 4'd0, 3'b000)));
    plan.push_back(by_model(mk(OP_SET, 8'h00, 6'd2, 3'd0, 4'd9, 3'b011)));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) issue(plan[i].w, plan[i].tag);

    while (words_sent < MID_WORDS) episode();

    // hold the sink off while full tx responses pile up behind it
    hold_req = 1'b1;
    repeat (4) run_frame(1'b1);
    drain();

    while (words_sent < BUSY_WORDS) episode();

    // advance without idling for the last stretch
    calm = 1'b1;
    while (words_sent < ALL_WORDS) episode();
    drain();
    repeat (SETTLE) @(posedge clk);

    if (n_faults == 0 && owed.size() == 0) begin
      $display("lin_slave_frame_handler_tb OK");
    end else begin
      $display("lin_slave_frame_handler_tb NOT OK");
    end
    $finish;
  end

endmodule
